/* hdl/rvalu_pkg.sv */
// Package for the RV64IM execute ALU: payload structs, operation and class codes,
// and small helpers shared by the pipeline and the divider.
// No dependencies.
`default_nettype none
package rvalu_pkg;

  localparam int unsigned Xlen     = 64;
  localparam int unsigned Wlen     = 32;
  localparam int unsigned DivSteps = Xlen;
  localparam logic [Xlen-1:0] PcStep = Xlen'(4);

  typedef enum logic [4:0] {
    OpAdd    = 5'd0,
    OpSub    = 5'd1,
    OpMul    = 5'd2,
    OpMulh   = 5'd3,
    OpMulhsu = 5'd4,
    OpMulhu  = 5'd5,
    OpDiv    = 5'd6,
    OpDivu   = 5'd7,
    OpRem    = 5'd8,
    OpRemu   = 5'd9,
    OpSll    = 5'd10,
    OpSra    = 5'd11,
    OpSrl    = 5'd12,
    OpXor    = 5'd13,
    OpOr     = 5'd14,
    OpAnd    = 5'd15,
    OpSlt    = 5'd16,
    OpSltu   = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    ClsRegReg   = 3'd0,
    ClsRegRegW  = 3'd1,
    ClsRegImm   = 3'd2,
    ClsRegImmW  = 3'd3,
    ClsBranch   = 3'd4,
    ClsAuipc    = 3'd5,
    ClsJal      = 3'd6,
    ClsJalr     = 3'd7
  } class_e;

  typedef enum logic [2:0] {
    BrEq  = 3'd0,
    BrNe  = 3'd1,
    BrLt  = 3'd2,
    BrGe  = 3'd3,
    BrLtu = 3'd4,
    BrGeu = 3'd5
  } bkind_e;

  typedef struct packed {
    logic [4:0]             op;
    logic [2:0]             instr_class;
    logic [Xlen-1:0]        rs1_value;
    logic [Xlen-1:0]        rs2_value;
    logic signed [Xlen-1:0] immediate;
    logic [Xlen-1:0]        instr_pc;
    logic [2:0]             branch_kind;
  } alu_in_t;

  typedef struct packed {
    logic [Xlen-1:0] alu_result;
    logic            branch_taken;
    logic [Xlen-1:0] second_value;
  } alu_out_t;

  // Everything that rides alongside the divider until the final select.
  typedef struct packed {
    logic [Xlen-1:0] res;       // non-divide result
    logic            is_div;
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic            div0;
    logic [Xlen-1:0] dividend;  // extended dividend, remainder on divide by zero
    logic            word;
    logic            taken;
    logic [Xlen-1:0] second;
  } side_t;

  function automatic logic [Xlen-1:0] sext32(input logic [Xlen-1:0] x);
    sext32 = {{(Xlen-Wlen){x[Wlen-1]}}, x[Wlen-1:0]};
  endfunction

endpackage
`default_nettype wire

/* hdl/rvalu_div.sv */
// Pipelined restoring divider: one quotient bit per stage, DivSteps stages.
// Carries a side struct in lockstep. Depends on rvalu_pkg.
`default_nettype none
module rvalu_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rvalu_pkg::Xlen-1:0]   ua_i,
  input  logic [rvalu_pkg::Xlen-1:0]   ub_i,
  input  rvalu_pkg::side_t             side_i,
  output logic                         valid_o,
  output logic [rvalu_pkg::Xlen-1:0]   quo_o,
  output logic [rvalu_pkg::Xlen-1:0]   rem_o,
  output rvalu_pkg::side_t             side_o
);
  import rvalu_pkg::*;

  // stage g holds the state after g+1 quotient bits
  logic            vld_q  [DivSteps];
  logic [Xlen-1:0] rem_q  [DivSteps];
  logic [Xlen-1:0] dq_q   [DivSteps];
  logic [Xlen-1:0] ub_q   [DivSteps];
  side_t           side_q [DivSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic            vld_in;
    logic [Xlen-1:0] rem_in;
    logic [Xlen-1:0] dq_in;
    logic [Xlen-1:0] ub_in;
    side_t           side_in;
    logic [Xlen:0]   sh;
    logic [Xlen:0]   diff;
    logic            ge;
    logic [Xlen-1:0] rem_d;
    logic [Xlen-1:0] dq_d;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign dq_in   = ua_i;
      assign ub_in   = ub_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign dq_in   = dq_q[g-1];
      assign ub_in   = ub_q[g-1];
      assign side_in = side_q[g-1];
    end

    // partial remainder stays below the divisor, so the borrow bit is the compare
    always_comb begin
      sh    = {rem_in, dq_in[Xlen-1]};
      diff  = sh - {1'b0, ub_in};
      ge    = !diff[Xlen];
      rem_d = ge ? diff[Xlen-1:0] : sh[Xlen-1:0];
      dq_d  = {dq_in[Xlen-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        dq_q[g]   <= dq_d;
        ub_q[g]   <= ub_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quo_o   = dq_q[DivSteps-1];
  assign rem_o   = rem_q[DivSteps-1];
  assign side_o  = side_q[DivSteps-1];

endmodule
`default_nettype wire

/* hdl/rv64im_execute_alu_core.sv */
// Top level of the RV64IM execute ALU: operand select, ALU, multiplier, branch
// compare, and the divider pipeline. Depends on rvalu_pkg and rvalu_div.
`default_nettype none
// One instruction enters per cycle and every instruction takes the same path, so
// results leave in order, passing through three front stages (decode and 32x32
// partial products, product sum, high-product fixup), 64 divider stages of one
// quotient bit each, and the output register. All stages move together; the pipe
// halts only while a result sits in the output register and out_ready_i is low,
// so throughput is one transaction per cycle when the pipe is not halted.
module rv64im_execute_alu_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rvalu_pkg::alu_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rvalu_pkg::alu_out_t  out_data_o
);
  import rvalu_pkg::*;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 1: decode, simple ops, partial products
  logic [Xlen-1:0] a, b, wa, wb, ua, simple;
  logic            word, sgn, na, nb, taken, ctl;
  logic [4:0]      sh5;
  logic [5:0]      sh6;

  always_comb begin
    word = (in_data_i.instr_class == ClsRegRegW) || (in_data_i.instr_class == ClsRegImmW);
    case (in_data_i.instr_class)
      ClsRegReg, ClsRegRegW: begin
        a = in_data_i.rs1_value; b = in_data_i.rs2_value;
      end
      ClsBranch, ClsAuipc, ClsJal: begin
        a = in_data_i.instr_pc; b = $unsigned(in_data_i.immediate);
      end
      default: begin
        a = in_data_i.rs1_value; b = $unsigned(in_data_i.immediate);
      end
    endcase
    sh5 = b[4:0];
    sh6 = b[5:0];
    case (in_data_i.op)
      OpAdd:   simple = a + b;
      OpSub:   simple = a - b;
      OpSll:   simple = word ? (a << sh5) : (a << sh6);
      OpSra:   simple = word ? Xlen'($signed(sext32(a)) >>> sh5) : Xlen'($signed(a) >>> sh6);
      OpSrl:   simple = word ? ({{(Xlen-Wlen){1'b0}}, a[Wlen-1:0]} >> sh5) : (a >> sh6);
      OpXor:   simple = a ^ b;
      OpOr:    simple = a | b;
      OpAnd:   simple = a & b;
      OpSlt:   simple = Xlen'($signed(a) < $signed(b));
      OpSltu:  simple = Xlen'(a < b);
      default: simple = '0;
    endcase
    sgn = (in_data_i.op == OpDiv) || (in_data_i.op == OpRem);
    wa  = word ? (sgn ? sext32(a) : {{(Xlen-Wlen){1'b0}}, a[Wlen-1:0]}) : a;
    wb  = word ? (sgn ? sext32(b) : {{(Xlen-Wlen){1'b0}}, b[Wlen-1:0]}) : b;
    na  = sgn && wa[Xlen-1];
    nb  = sgn && wb[Xlen-1];
    ua  = na ? (Xlen'(0) - wa) : wa;
    case (in_data_i.branch_kind)
      BrEq:    taken = in_data_i.rs1_value == in_data_i.rs2_value;
      BrNe:    taken = in_data_i.rs1_value != in_data_i.rs2_value;
      BrLt:    taken = $signed(in_data_i.rs1_value) < $signed(in_data_i.rs2_value);
      BrGe:    taken = $signed(in_data_i.rs1_value) >= $signed(in_data_i.rs2_value);
      BrLtu:   taken = in_data_i.rs1_value < in_data_i.rs2_value;
      BrGeu:   taken = in_data_i.rs1_value >= in_data_i.rs2_value;
      default: taken = 1'b0;
    endcase
    taken = taken && (in_data_i.instr_class == ClsBranch);
    ctl   = (in_data_i.instr_class == ClsBranch) || (in_data_i.instr_class == ClsJal) ||
            (in_data_i.instr_class == ClsJalr);
  end

  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  logic [4:0]          s1_op_q, s2_op_q;
  logic [Xlen-1:0]     s1_a_q, s1_b_q, s2_a_q, s2_b_q;
  logic [2*Wlen-1:0]   s1_ll_q, s1_lh_q, s1_hl_q, s1_hh_q;
  logic [2*Xlen-1:0]   s2_prod_q;
  logic [Xlen-1:0]     s1_ua_q, s2_ua_q, s3_ua_q;
  logic [Xlen-1:0]     s1_ub_q, s2_ub_q, s3_ub_q;
  side_t               s1_side_q, s2_side_q, s3_side_q;
  side_t               s1_side_d;

  always_comb begin
    s1_side_d          = '0;
    s1_side_d.res      = simple;
    s1_side_d.is_div   = (in_data_i.op == OpDiv) || (in_data_i.op == OpDivu) ||
                         (in_data_i.op == OpRem) || (in_data_i.op == OpRemu);
    s1_side_d.want_rem = (in_data_i.op == OpRem) || (in_data_i.op == OpRemu);
    s1_side_d.neg_q    = na ^ nb;
    s1_side_d.neg_r    = na;
    s1_side_d.div0     = wb == '0;
    s1_side_d.dividend = wa;
    s1_side_d.word     = word;
    s1_side_d.taken    = taken;
    s1_side_d.second   = ctl ? (in_data_i.instr_pc + PcStep) : in_data_i.rs2_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // ---------------- stage 2: sum partial products; stage 3: high-product fixup
  logic [Xlen-1:0] hi_fix;
  side_t           s3_side_d;

  always_comb begin
    hi_fix = s2_prod_q[2*Xlen-1:Xlen];
    if (((s2_op_q == OpMulh) || (s2_op_q == OpMulhsu)) && s2_a_q[Xlen-1]) begin
      hi_fix = hi_fix - s2_b_q;
    end
    if ((s2_op_q == OpMulh) && s2_b_q[Xlen-1]) begin
      hi_fix = hi_fix - s2_a_q;
    end
    s3_side_d = s2_side_q;
    case (s2_op_q)
      OpMul:                     s3_side_d.res = s2_prod_q[Xlen-1:0];
      OpMulh, OpMulhsu, OpMulhu: s3_side_d.res = hi_fix;
      default:                   s3_side_d.res = s2_side_q.res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q   <= in_data_i.op;
      s1_a_q    <= a;
      s1_b_q    <= b;
      s1_ll_q   <= a[Wlen-1:0] * b[Wlen-1:0];
      s1_lh_q   <= a[Wlen-1:0] * b[Xlen-1:Wlen];
      s1_hl_q   <= a[Xlen-1:Wlen] * b[Wlen-1:0];
      s1_hh_q   <= a[Xlen-1:Wlen] * b[Xlen-1:Wlen];
      s1_ua_q   <= ua;
      s1_ub_q   <= nb ? (Xlen'(0) - wb) : wb;
      s1_side_q <= s1_side_d;

      s2_op_q   <= s1_op_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_prod_q <= {{Xlen{1'b0}}, s1_ll_q}
                 + {{Wlen{1'b0}}, s1_lh_q, {Wlen{1'b0}}}
                 + {{Wlen{1'b0}}, s1_hl_q, {Wlen{1'b0}}}
                 + {s1_hh_q, {Xlen{1'b0}}};
      s2_ua_q   <= s1_ua_q;
      s2_ub_q   <= s1_ub_q;
      s2_side_q <= s1_side_q;

      s3_ua_q   <= s2_ua_q;
      s3_ub_q   <= s2_ub_q;
      s3_side_q <= s3_side_d;
    end
  end

  // ---------------- divider pipeline
  logic            dv_valid;
  logic [Xlen-1:0] dv_quo, dv_rem;
  side_t           dv_side;

  rvalu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .ua_i    (s3_ua_q),
    .ub_i    (s3_ub_q),
    .side_i  (s3_side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .side_o  (dv_side)
  );

  // ---------------- output select and register
  logic [Xlen-1:0] fin;
  alu_out_t        out_q;

  always_comb begin
    if (!dv_side.is_div) begin
      fin = dv_side.res;
    end else if (dv_side.div0) begin
      fin = dv_side.want_rem ? dv_side.dividend : '1;
    end else if (dv_side.want_rem) begin
      fin = dv_side.neg_r ? (Xlen'(0) - dv_rem) : dv_rem;
    end else begin
      fin = dv_side.neg_q ? (Xlen'(0) - dv_quo) : dv_quo;
    end
    if (dv_side.word) begin
      fin = sext32(fin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.alu_result   <= fin;
      out_q.branch_taken <= dv_side.taken;
      out_q.second_value <= dv_side.second;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s1_valid_q) && $stable(s3_valid_q) && $stable(out_valid_q))
    else $error("pipeline moved while stalled");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_side_q.is_div && !s3_side_q.div0 |-> s3_ub_q != '0)
    else $error("divider fed zero divisor without divide-by-zero flag");

  a_taken_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_side_q.taken |-> s1_side_q.res == s1_a_q + s1_b_q || s1_op_q != OpAdd)
    else $error("branch taken flag with inconsistent target");
`endif

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for rv64im_execute_alu_core: directed and random instructions
// over valid/ready, checked against an in-bench predictor. Depends on rvalu_pkg.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvalu_pkg::*;

  class alu_scoreboard;
    alu_out_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function automatic logic [63:0] sx32(logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] divide(logic [63:0] a, logic [63:0] b, bit sgn, bit rem);
      logic [63:0] ua, ub, q, r;
      bit na, nb;
      if (b == 64'd0) return rem ? a : '1;
      if (!sgn) return rem ? a % b : a / b;
      na = a[63];
      nb = b[63];
      ua = na ? -a : a;
      ub = nb ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (na != nb) q = -q;
      if (na) r = -r;
      return rem ? r : q;
    endfunction

    function automatic alu_out_t execute(alu_in_t t);
      alu_out_t o;
      logic [63:0] a, b, res;
      logic [127:0] pa, pb, prod;
      bit word, sgn, rem;
      word = (t.instr_class == ClsRegRegW) || (t.instr_class == ClsRegImmW);
      case (t.instr_class)
        ClsRegReg, ClsRegRegW: begin a = t.rs1_value; b = t.rs2_value; end
        ClsBranch, ClsAuipc, ClsJal: begin a = t.instr_pc; b = t.immediate; end
        default: begin a = t.rs1_value; b = t.immediate; end
      endcase
      pa = {{64{a[63]}}, a};
      pb = {{64{b[63]}}, b};
      res = '0;
      case (t.op)
        OpAdd: res = a + b;
        OpSub: res = a - b;
        OpMul: res = a * b;
        OpMulh: begin prod = pa * pb; res = prod[127:64]; end
        OpMulhsu: begin prod = pa * {64'd0, b}; res = prod[127:64]; end
        OpMulhu: begin prod = {64'd0, a} * {64'd0, b}; res = prod[127:64]; end
        OpDiv, OpDivu, OpRem, OpRemu: begin
          sgn = (t.op == OpDiv) || (t.op == OpRem);
          rem = (t.op == OpRem) || (t.op == OpRemu);
          if (word)
            res = divide(sgn ? sx32(a) : {32'd0, a[31:0]}, sgn ? sx32(b) : {32'd0, b[31:0]},
                         sgn, rem);
          else
            res = divide(a, b, sgn, rem);
        end
        OpSll: res = word ? a << b[4:0] : a << b[5:0];
        OpSra: res = word ? $signed(sx32(a)) >>> b[4:0] : $signed(a) >>> b[5:0];
        OpSrl: res = word ? {32'd0, a[31:0]} >> b[4:0] : a >> b[5:0];
        OpXor: res = a ^ b;
        OpOr:  res = a | b;
        OpAnd: res = a & b;
        OpSlt: res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
        OpSltu: res = (a < b) ? 64'd1 : 64'd0;
        default: res = '0;
      endcase
      if (word) res = sx32(res);
      o.alu_result = res;
      o.branch_taken = 1'b0;
      if (t.instr_class == ClsBranch) begin
        case (t.branch_kind)
          BrEq:  o.branch_taken = (t.rs1_value == t.rs2_value);
          BrNe:  o.branch_taken = (t.rs1_value != t.rs2_value);
          BrLt:  o.branch_taken = ($signed(t.rs1_value) < $signed(t.rs2_value));
          BrGe:  o.branch_taken = ($signed(t.rs1_value) >= $signed(t.rs2_value));
          BrLtu: o.branch_taken = (t.rs1_value < t.rs2_value);
          BrGeu: o.branch_taken = (t.rs1_value >= t.rs2_value);
          default: o.branch_taken = 1'b0;
        endcase
      end
      o.second_value = (t.instr_class == ClsBranch || t.instr_class == ClsJal ||
                        t.instr_class == ClsJalr) ? t.instr_pc + 64'd4 : t.rs2_value;
      return o;
    endfunction

    function void note_input(alu_in_t t);
      expected_q = {expected_q, execute(t)};
    endfunction

    function void check_result(alu_out_t got);
      alu_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.alu_result !== want.alu_result || got.branch_taken !== want.branch_taken ||
          got.second_value !== want.second_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp res=%h tk=%b sec=%h got res=%h tk=%b sec=%h",
                   want.alu_result, want.branch_taken, want.second_value,
                   got.alu_result, got.branch_taken, got.second_value);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  alu_in_t in_data_i;
  alu_out_t out_data_o;

  alu_scoreboard sb;
  bit quiet;
  int unsigned cycles;
  int unsigned sent;

  localparam int unsigned CycleLimit = 400000;

  rv64im_execute_alu_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: check accepted transactions, stall at random
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (rst_ni) out_ready_i <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'($urandom_range(0, 70));
      5: return {32'hffff_ffff, 32'h8000_0000 | $urandom_range(0, 3)};
      6: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_in_t make_insn(logic [4:0] op, logic [2:0] cls, logic [63:0] r1,
                                         logic [63:0] r2, logic [63:0] imm, logic [63:0] pc,
                                         logic [2:0] kind);
    alu_in_t t;
    t.op = op; t.instr_class = cls; t.rs1_value = r1; t.rs2_value = r2;
    t.immediate = imm; t.instr_pc = pc; t.branch_kind = kind;
    return t;
  endfunction

  task automatic send_insn(alu_in_t t);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(t);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

  initial begin
    alu_in_t t;
    sb = new();
    quiet = 1'b0;
    cycles = 0;
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    in_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every op on extremes, divide corner cases, word forms, unused codes
    for (int op = 0; op < 18; op++)
      send_insn(make_insn(5'(op), ClsRegReg, '1, MinNeg, '0, '1, BrEq));
    send_insn(make_insn(OpDiv, ClsRegReg, MinNeg, '1, '0, 64'd0, BrEq));
    send_insn(make_insn(OpRem, ClsRegReg, MinNeg, '1, '0, 64'd0, BrEq));
    send_insn(make_insn(OpDivu, ClsRegReg, 64'd77, 64'd0, '0, 64'd0, BrEq));
    send_insn(make_insn(OpRemu, ClsRegRegW, 64'h1_8000_0005, 64'h1_0000_0000, '0, 64'd0,
                        BrEq));
    send_insn(make_insn(OpDiv, ClsRegRegW, 64'h8000_0000, '1, '0, 64'd0, BrEq));
    send_insn(make_insn(OpSra, ClsRegImmW, 64'h8000_0000, 64'd0, 64'd63, 64'd0, BrEq));
    send_insn(make_insn(OpMulh, ClsRegRegW, MinNeg, MinNeg, '0, 64'd0, BrEq));
    send_insn(make_insn(5'd31, ClsJalr, '1, '1, '1, '1, 3'd7));
    send_insn(make_insn(OpAdd, ClsBranch, '1, '1, 64'hffff_ffff_ffff_fff0, '1, 3'd6));
    send_insn(make_insn(OpAdd, ClsBranch, '1, 64'd1, 64'd8, 64'h7ffc, BrLt));
    drain();

    for (int n = 0; n < 2000; n++) begin
      quiet = (n >= 700 && n < 1000);
      if (n == 1400) drain();
      t.op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
      t.instr_class = 3'($urandom_range(0, 7));
      t.rs1_value = pick64();
      t.rs2_value = ($urandom_range(0, 5) == 0) ? t.rs1_value : pick64();
      t.immediate = pick64();
      t.instr_pc = pick64();
      t.branch_kind = 3'($urandom_range(0, 7));
      send_insn(t);
    end
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Ran %0d instructions over all ops, classes and branch kinds; %0d results checked.",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
